@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the checker files.
// Expects signals named clk and rst_n in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is asserted.
`define ASSERT_CLK(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Clocked assertion that also runs through reset.
`define ASSERT_CLK_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

@@ rtl/core/hte_pkg.sv @@
// Shared types and constants for the humidity/temperature frame decoder.
// No dependencies; used by every module of the block.
`default_nettype none

package hte_pkg;

  localparam int unsigned FRAME_BYTES = 7;
  localparam logic [2:0]  FRAME_LAST_IDX = 3'(FRAME_BYTES - 1);

  localparam logic [7:0]  CRC_INIT = 8'hFF;
  localparam logic [7:0]  BUSY_MASK = 8'h80;
  localparam logic [7:0]  NIBBLE_MASK = 8'h0F;

  localparam logic [10:0] TEMP_MUL = 11'd1250;
  localparam logic [16:0] TEMP_BIAS = 17'd5000;
  localparam logic [9:0]  HUMI_MUL = 10'd625;
  localparam logic [13:0] HUMI_MAX = 14'd9999;

  // Frame status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_BUSY  = 2'd1;
  localparam logic [1:0] STATUS_CRC   = 2'd2;
  localparam logic [1:0] STATUS_FAULT = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_CRC_POLY  = 2'd0;
  localparam logic [1:0] CFG_TEMP_TRIM = 2'd1;
  localparam logic [1:0] CFG_HUMI_TRIM = 2'd2;

  localparam logic [7:0] CRC_POLY_RESET = 8'h31;

  // One classified frame, handed from the front end to the converter
  typedef struct packed {
    logic [1:0]  status;
    logic [19:0] raw_temp;
    logic [19:0] raw_humi;
  } frame_rec_t;

  // Push side of the frame queue
  typedef struct packed {
    logic       push;
    frame_rec_t rec;
  } frame_push_t;

endpackage

`default_nettype wire

@@ rtl/core/hte_front.sv @@
// Byte front end: frame index, CRC-8, flags and raw field assembly.
// Depends on hte_pkg; pushes one record per completed frame.
`default_nettype none

module hte_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               accept,
  input  wire logic [7:0]         rx_byte,
  input  wire logic               frame_start,
  input  wire logic               bus_fault,
  input  wire logic [7:0]         crc_poly,
  output hte_pkg::frame_push_t    push_o
);

  logic [2:0]  idx_r;
  logic [7:0]  crc_r;
  logic        busy_r;
  logic        fault_r;
  logic [19:0] raw_humi_r;
  logic [19:0] raw_temp_r;

  logic [2:0]  base_idx;
  logic [7:0]  base_crc;
  logic        base_busy;
  logic        base_fault;
  logic [7:0]  crc_nxt;
  logic        fault_acc;
  logic        last_byte;
  logic [1:0]  status;

  function automatic logic [7:0] crc8_step(input logic [7:0] crc,
                                           input logic [7:0] data,
                                           input logic [7:0] poly);
    logic [7:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ poly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

  always_comb begin
    // A start marker restarts the frame and takes this byte as byte 0
    base_idx   = frame_start ? 3'd0 : idx_r;
    base_crc   = frame_start ? hte_pkg::CRC_INIT : crc_r;
    base_busy  = frame_start ? 1'b0 : busy_r;
    base_fault = frame_start ? 1'b0 : fault_r;
    crc_nxt    = crc8_step(base_crc, rx_byte, crc_poly);
    fault_acc  = base_fault | bus_fault;
    last_byte  = (base_idx == hte_pkg::FRAME_LAST_IDX);

    if (fault_acc) begin
      status = hte_pkg::STATUS_FAULT;
    end else if (base_busy) begin
      status = hte_pkg::STATUS_BUSY;
    end else if (crc_nxt != 8'd0) begin
      status = hte_pkg::STATUS_CRC;
    end else begin
      status = hte_pkg::STATUS_OK;
    end

    push_o.push          = accept & last_byte;
    push_o.rec.status    = status;
    push_o.rec.raw_temp  = raw_temp_r;
    push_o.rec.raw_humi  = raw_humi_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= 3'd0;
      crc_r   <= hte_pkg::CRC_INIT;
      busy_r  <= 1'b0;
      fault_r <= 1'b0;
    end else if (accept) begin
      if (last_byte) begin
        idx_r   <= 3'd0;
        crc_r   <= hte_pkg::CRC_INIT;
        busy_r  <= 1'b0;
        fault_r <= 1'b0;
      end else begin
        idx_r   <= base_idx + 3'd1;
        crc_r   <= crc_nxt;
        busy_r  <= (base_idx == 3'd0) ? ((rx_byte & hte_pkg::BUSY_MASK) != 8'd0)
                                      : base_busy;
        fault_r <= fault_acc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      unique case (base_idx)
        3'd1: raw_humi_r <= {rx_byte, 12'd0};
        3'd2: raw_humi_r <= {raw_humi_r[19:12], rx_byte, 4'd0};
        3'd3: begin
          raw_humi_r <= {raw_humi_r[19:4], rx_byte[7:4]};
          raw_temp_r <= {4'(rx_byte & hte_pkg::NIBBLE_MASK), 16'd0};
        end
        3'd4: raw_temp_r <= {raw_temp_r[19:16], rx_byte, 8'd0};
        3'd5: raw_temp_r <= {raw_temp_r[19:8], rx_byte};
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/hte_queue.sv @@
// Small frame record queue between the front end and the converter.
// Depends on hte_pkg for the record type.
`default_nettype none

module hte_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire hte_pkg::frame_push_t push_i,
  input  wire logic                 pop,
  output hte_pkg::frame_rec_t       pop_data,
  output logic                      empty,
  output logic                      full
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  hte_pkg::frame_rec_t mem [DEPTH];
  logic [PTR_W-1:0]    wr_ptr_r;
  logic [PTR_W-1:0]    rd_ptr_r;
  logic [CNT_W-1:0]    count_r;
  logic                do_push;
  logic                do_pop;

  assign empty    = (count_r == CNT_W'(0));
  assign full     = (count_r == CNT_W'(DEPTH));
  assign do_push  = push_i.push & ~full;
  assign do_pop   = pop & ~empty;
  assign pop_data = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_i.rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/hte_back.sv @@
// Converter back end: scale, offset and clamp, last-good hold, output register.
// Depends on hte_pkg; pops frame records from hte_queue.
`default_nettype none

module hte_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                q_empty,
  input  wire hte_pkg::frame_rec_t q_data,
  output logic                     q_pop,
  input  wire logic [14:0]         temp_trim,
  input  wire logic [14:0]         humi_trim,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [1:0]               out_status,
  output logic signed [15:0]       out_temperature,
  output logic [13:0]              out_humidity
);

  // Stage 1: products
  logic        s1_valid_r;
  logic [1:0]  s1_status_r;
  logic [30:0] t_prod_r;
  logic [29:0] h_prod_r;

  // Last good values
  logic [15:0] last_temp_r;
  logic [13:0] last_humi_r;

  // Output register
  logic        out_valid_r;
  logic [1:0]  out_status_r;
  logic [15:0] out_temp_r;
  logic [13:0] out_humi_r;

  logic        out_free;
  logic        s1_move;
  logic        s1_ready;
  logic signed [16:0] t_sum;
  logic signed [16:0] h_sum;
  logic [13:0] h_clamped;
  logic        frame_ok;

  assign out_free = ~out_valid_r | ~out_stall;
  assign s1_move  = s1_valid_r & out_free;
  assign s1_ready = ~s1_valid_r | out_free;
  assign q_pop    = ~q_empty & s1_ready;
  assign frame_ok = (s1_status_r == hte_pkg::STATUS_OK);

  always_comb begin
    t_sum = signed'({2'b00, t_prod_r[30:16]}) - signed'(hte_pkg::TEMP_BIAS)
          + signed'({{2{temp_trim[14]}}, temp_trim});
    h_sum = signed'({3'b000, h_prod_r[29:16]})
          + signed'({{2{humi_trim[14]}}, humi_trim});
    if (h_sum < 17'sd0) begin
      h_clamped = 14'd0;
    end else if (h_sum > signed'({3'b000, hte_pkg::HUMI_MAX})) begin
      h_clamped = hte_pkg::HUMI_MAX;
    end else begin
      h_clamped = h_sum[13:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_r <= q_pop;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_status_r <= q_data.status;
      t_prod_r    <= 31'(q_data.raw_temp) * 31'(hte_pkg::TEMP_MUL);
      h_prod_r    <= 30'(q_data.raw_humi) * 30'(hte_pkg::HUMI_MUL);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_temp_r <= 16'd0;
      last_humi_r <= 14'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_move) begin
        out_valid_r <= 1'b1;
        if (frame_ok) begin
          last_temp_r <= t_sum[15:0];
          last_humi_r <= h_clamped;
        end
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Error frames repeat the last good values
  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_status_r <= s1_status_r;
      out_temp_r   <= frame_ok ? t_sum[15:0] : last_temp_r;
      out_humi_r   <= frame_ok ? h_clamped : last_humi_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_temperature = signed'(out_temp_r);
  assign out_humidity    = out_humi_r;

endmodule

`default_nettype wire

@@ rtl/core/humidity_temperature_frame_decode.sv @@
// Humidity/temperature sensor reply decoder, top level.
// Channels: input bytes (in_valid/in_stall) carry rx_byte, frame_start and
// bus_fault; results (out_valid/out_stall) carry status, temperature in
// 0.01 C and humidity in 0.01 %. The cfg port writes crc_poly (index 0),
// the temperature trim (index 1) and the humidity trim (index 2); the user
// must see that they are taken only while idle, which the block does not
// enforce. One byte is taken every cycle while in_stall is low. A frame is
// seven bytes; the seventh byte produces one result, which passes through
// the queue pop, the multiply stage and the output register to out_valid.
// Front end and converter are parted by a QUEUE_DEPTH record queue, so the
// front end keeps taking bytes while a result waits at the output.
// When the receiver stalls, the result holds, the converter stops, and
// in_stall rises only once the queue is full.
// Synchronous reset clears the frame state, the last good values, the
// queue and the configuration registers to their defaults.
// Depends on hte_pkg, hte_front, hte_queue and hte_back.
`default_nettype none

module humidity_temperature_frame_decode #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [7:0]         in_rx_byte,
  input  wire logic               in_frame_start,
  input  wire logic               in_bus_fault,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [1:0]              out_status,
  output logic signed [15:0]      out_temperature,
  output logic [13:0]             out_humidity,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [14:0]        cfg_wdata
);

  logic [7:0]  crc_poly_r;
  logic [14:0] temp_trim_r;
  logic [14:0] humi_trim_r;

  logic                 accept;
  logic                 q_full;
  logic                 q_empty;
  logic                 q_pop;
  hte_pkg::frame_push_t push;
  hte_pkg::frame_rec_t  q_data;

  assign in_stall = q_full;
  assign accept   = in_valid & ~q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_poly_r  <= hte_pkg::CRC_POLY_RESET;
      temp_trim_r <= 15'd0;
      humi_trim_r <= 15'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hte_pkg::CFG_CRC_POLY:  crc_poly_r  <= cfg_wdata[7:0];
        hte_pkg::CFG_TEMP_TRIM: temp_trim_r <= cfg_wdata;
        hte_pkg::CFG_HUMI_TRIM: humi_trim_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  hte_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .rx_byte     (in_rx_byte),
    .frame_start (in_frame_start),
    .bus_fault   (in_bus_fault),
    .crc_poly    (crc_poly_r),
    .push_o      (push)
  );

  hte_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_i   (push),
    .pop      (q_pop),
    .pop_data (q_data),
    .empty    (q_empty),
    .full     (q_full)
  );

  hte_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_data          (q_data),
    .q_pop           (q_pop),
    .temp_trim       (temp_trim_r),
    .humi_trim       (humi_trim_r),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_temperature (out_temperature),
    .out_humidity    (out_humidity)
  );

endmodule

`default_nettype wire

@@ rtl/core/hte_checker.sv @@
// Port-level checks for the frame decoder, bound to the top level.
// Depends on hte_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module hte_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic [1:0]         out_status,
  input wire logic signed [15:0] out_temperature,
  input wire logic [13:0]        out_humidity
);

  // Hold a stalled result
  `ASSERT_CLK(a_out_hold, out_valid && out_stall |=> out_valid, "stalled result dropped")
  `ASSERT_CLK(a_out_stable, out_valid && out_stall |=> $stable({out_status, out_temperature, out_humidity}), "stalled result changed")
  // Humidity always clamped, also when repeated after an error
  `ASSERT_CLK(a_humi_range, out_valid |-> out_humidity <= hte_pkg::HUMI_MAX, "humidity above clamp")
  // No result right out of reset
  `ASSERT_CLK_ALWAYS(a_reset_quiet, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind humidity_temperature_frame_decode hte_checker u_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_status      (out_status),
  .out_temperature (out_temperature),
  .out_humidity    (out_humidity)
);

`default_nettype wire

@@ tb/sv/tb_top.sv @@
// Self-checking bench for humidity_temperature_frame_decode: byte stream in,
// decoded readings out, checked against an in-bench decoder predictor.
// Depends on hte_pkg and the decoder RTL only.
module tb_top;
  import hte_pkg::*;

  localparam int LIMIT = 400000;
  localparam int HOLD_CYCLES = 150;
  localparam int PHASES = 8;
  localparam int PHASE_BYTES = 210;

  typedef struct {
    logic [1:0]         status;
    logic signed [15:0] temperature;
    logic [13:0]        humidity;
  } reading_t;

  class reading_scoreboard;
    logic [7:0]         crc_poly;
    logic signed [14:0] temp_trim;
    logic signed [14:0] humi_trim;
    logic [2:0]         byte_idx;
    logic [7:0]         crc;
    bit                 busy;
    bit                 fault;
    logic [19:0]        raw_humi;
    logic [19:0]        raw_temp;
    logic signed [15:0] last_temp;
    logic [13:0]        last_humi;
    reading_t           due_readings[$];
    int                 errors;
    int                 bytes_seen;
    int                 status_count[4];

    function new();
      crc_poly = CRC_POLY_RESET;
      temp_trim = '0;
      humi_trim = '0;
      byte_idx = '0;
      crc = CRC_INIT;
      busy = 1'b0;
      fault = 1'b0;
      raw_humi = '0;
      raw_temp = '0;
      last_temp = '0;
      last_humi = '0;
      errors = 0;
      bytes_seen = 0;
      for (int i = 0; i < 4; i++) status_count[i] = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [14:0] data);
      case (idx)
        CFG_CRC_POLY:  crc_poly = data[7:0];
        CFG_TEMP_TRIM: temp_trim = data;
        CFG_HUMI_TRIM: humi_trim = data;
        default: ;
      endcase
    endfunction

    // MSB-first CRC-8 step over one byte
    function logic [7:0] crc_next(logic [7:0] c, logic [7:0] b);
      logic [7:0] r;
      r = c ^ b;
      for (int i = 0; i < 8; i++) r = r[7] ? ((r << 1) ^ crc_poly) : (r << 1);
      return r;
    endfunction

    function void take_byte(logic [7:0] b, logic start, logic flt);
      logic [2:0]  idx;
      logic [1:0]  st;
      logic [31:0] prod;
      int          t;
      int          h;
      int          off;
      reading_t    rd;
      bytes_seen++;
      if (start) begin
        byte_idx = '0;
        crc = CRC_INIT;
        busy = 1'b0;
        fault = 1'b0;
      end
      idx = byte_idx;
      if (flt) fault = 1'b1;
      crc = crc_next(crc, b);
      case (idx)
        3'd0: busy = b[7];
        3'd1: raw_humi = {b, 12'h000};
        3'd2: raw_humi = {raw_humi[19:12], b, 4'h0};
        3'd3: begin
          raw_humi[3:0] = b[7:4];
          raw_temp = {b[3:0], 16'h0000};
        end
        3'd4: raw_temp = {raw_temp[19:16], b, 8'h00};
        3'd5: raw_temp[7:0] = b;
        default: ;
      endcase
      if (idx != FRAME_LAST_IDX) begin
        byte_idx = idx + 3'd1;
        return;
      end
      byte_idx = '0;
      if (fault) st = STATUS_FAULT;
      else if (busy) st = STATUS_BUSY;
      else if (crc != 8'h00) st = STATUS_CRC;
      else st = STATUS_OK;
      if (st == STATUS_OK) begin
        prod = 32'(raw_temp) * 32'd1250;
        off = temp_trim;
        t = int'(prod >> 16) - 5000 + off;
        prod = 32'(raw_humi) * 32'd625;
        off = humi_trim;
        h = int'(prod >> 16) + off;
        if (h < 0) h = 0;
        else if (h > 9999) h = 9999;
        last_temp = t[15:0];
        last_humi = h[13:0];
      end
      crc = CRC_INIT;
      busy = 1'b0;
      fault = 1'b0;
      rd.status = st;
      rd.temperature = last_temp;
      rd.humidity = last_humi;
      due_readings.push_back(rd);
    endfunction

    function void check_reading(logic [1:0] st, logic signed [15:0] temp, logic [13:0] humi);
      reading_t e;
      if (due_readings.size() == 0) begin
        $error("reading with status %0d arrived but no frame is outstanding", st);
        errors++;
        return;
      end
      e = due_readings.pop_front();
      status_count[e.status]++;
      if (st !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, st);
        errors++;
      end
      if (temp !== e.temperature) begin
        $error("temperature: expected %0d, got %0d", e.temperature, temp);
        errors++;
      end
      if (humi !== e.humidity) begin
        $error("humidity: expected %0d, got %0d", e.humidity, humi);
        errors++;
      end
    endfunction

    function int pending();
      return due_readings.size();
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [7:0]         in_rx_byte;
  logic               in_frame_start;
  logic               in_bus_fault;
  logic               out_valid;
  logic               out_stall;
  logic [1:0]         out_status;
  logic signed [15:0] out_temperature;
  logic [13:0]        out_humidity;
  logic               cfg_we;
  logic [1:0]         cfg_index;
  logic [14:0]        cfg_wdata;

  reading_scoreboard sb = new();
  bit  calm = 1'b0;
  bit  hold_request = 1'b0;
  int  cycle_count = 0;

  humidity_temperature_frame_decode dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_rx_byte      (in_rx_byte),
    .in_frame_start  (in_frame_start),
    .in_bus_fault    (in_bus_fault),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_temperature (out_temperature),
    .out_humidity    (out_humidity),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Record config writes and byte transfers before checking readings
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) sb.write_reg(cfg_index, cfg_wdata);
      if (in_valid && !in_stall) sb.take_byte(in_rx_byte, in_frame_start, in_bus_fault);
      if (out_valid && !out_stall) sb.check_reading(out_status, out_temperature, out_humidity);
    end
  end

  // Receiver: random stalls, or a long hold when requested
  initial begin
    int hold_left;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_left = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 23);
      end
    end
  end

  initial begin
    while (cycle_count < LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timed out after %0d cycles with %0d readings due", LIMIT, sb.pending());
    $display("status: fail");
    $finish;
  end

  // All tasks are entered and left at a falling edge
  task automatic write_reg(input logic [1:0] idx, input logic [14:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_byte(input logic [7:0] b, input logic start, input logic flt);
    while (!calm && $urandom_range(99) < 23) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    in_frame_start <= start;
    in_bus_fault <= flt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Build a reply at the current polynomial; fault_pos < 0 means a clean bus
  task automatic send_frame(input logic [19:0] rh, input logic [19:0] rt, input bit busy_bit,
                            input bit bad_crc, input int fault_pos, input bit with_start);
    logic [7:0] f[7];
    logic [7:0] c;
    f[0] = {busy_bit, 7'($urandom)};
    f[1] = rh[19:12];
    f[2] = rh[11:4];
    f[3] = {rh[3:0], rt[19:16]};
    f[4] = rt[15:8];
    f[5] = rt[7:0];
    c = CRC_INIT;
    for (int i = 0; i < 6; i++) c = sb.crc_next(c, f[i]);
    f[6] = bad_crc ? (c ^ 8'($urandom_range(255, 1))) : c;
    for (int i = 0; i < 7; i++) send_byte(f[i], (i == 0) && with_start, i == fault_pos);
  endtask

  function automatic logic [19:0] pick_raw();
    case ($urandom_range(9))
      0: return 20'h00000;
      1: return 20'hFFFFF;
      default: return 20'($urandom);
    endcase
  endfunction

  task automatic random_traffic(input int n);
    int sent;
    int r;
    int k;
    sent = 0;
    while (sent < n) begin
      r = $urandom_range(99);
      if (r < 78) begin
        send_frame(pick_raw(), pick_raw(), $urandom_range(99) < 8, $urandom_range(99) < 8,
                   ($urandom_range(99) < 6) ? int'($urandom_range(6)) : -1,
                   $urandom_range(99) < 85);
        sent += 7;
      end else if (r < 90) begin
        // truncated reply: restart, then drop out early
        k = $urandom_range(6, 1);
        for (int i = 0; i < k; i++)
          send_byte(8'($urandom), i == 0, $urandom_range(99) < 5);
        sent += k;
      end else begin
        send_byte(8'($urandom), $urandom_range(1), $urandom_range(99) < 20);
        sent += 1;
      end
    end
    in_valid <= 1'b0;
  endtask

  task automatic drain_readings();
    while (sb.pending() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  initial begin
    int p;
    logic [7:0] poly;
    int toff;
    int hoff;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_rx_byte = '0;
    in_frame_start = 1'b0;
    in_bus_fault = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_CRC_POLY;
    cfg_wdata = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Largest raw values, then a restart in mid-reply carrying every error,
    // then a busy reply with a bad CRC that follows without a start marker
    send_frame(20'hFFFFF, 20'hFFFFF, 1'b0, 1'b0, -1, 1'b1);
    send_byte(8'($urandom), 1'b1, 1'b0);
    send_byte(8'($urandom), 1'b0, 1'b0);
    send_frame(20'h00000, 20'h00000, 1'b1, 1'b1, 2, 1'b1);
    send_frame(20'h00000, 20'hFFFFF, 1'b1, 1'b1, -1, 1'b0);
    in_valid <= 1'b0;
    drain_readings();

    for (p = 0; p < PHASES; p++) begin
      case (p)
        0: begin poly = 8'h31; toff = 10000;  hoff = 10000;  end
        1: begin poly = 8'h07; toff = -10000; hoff = -10000; end
        2: begin poly = 8'h00; toff = 16383;  hoff = -16384; end
        3: begin poly = 8'hFF; toff = -16384; hoff = 16383;  end
        4: begin poly = 8'h31; toff = 0;      hoff = 0;      end
        default: begin
          poly = 8'($urandom);
          toff = int'($urandom_range(20000)) - 10000;
          hoff = int'($urandom_range(20000)) - 10000;
        end
      endcase
      write_reg(CFG_CRC_POLY, 15'(poly));
      write_reg(CFG_TEMP_TRIM, 15'(toff));
      write_reg(CFG_HUMI_TRIM, 15'(hoff));
      calm = (p == 2);
      // back up the result path so the queue fills and the input stalls
      if (p == 1 || p == 5) hold_request = 1'b1;
      random_traffic(PHASE_BYTES);
      drain_readings();
    end
    calm = 1'b0;

    if (sb.pending() != 0) begin
      $error("%0d readings never arrived", sb.pending());
      sb.errors++;
    end
    $display("Decoded %0d bytes into readings: %0d ok, %0d busy, %0d crc mismatch, %0d bus fault",
             sb.bytes_seen, sb.status_count[STATUS_OK], sb.status_count[STATUS_BUSY],
             sb.status_count[STATUS_CRC], sb.status_count[STATUS_FAULT]);
    $display("Covered %0d config sets incl. extreme offsets and polynomials, %0d mismatches",
             PHASES, sb.errors);
    if (sb.errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule

@@ humidity_temperature_frame_decode.f @@
+incdir+rtl/core
rtl/core/hte_pkg.sv
rtl/core/hte_front.sv
rtl/core/hte_queue.sv
rtl/core/hte_back.sv
rtl/core/humidity_temperature_frame_decode.sv
rtl/core/hte_checker.sv
tb/sv/tb_top.sv
